// ===== design/lfce_pkg.sv =====
// ----------------------------------------------------------------------------
// Loop flag condition engine package
// Shared payload types, operation and comparator codes, default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package lfce_pkg;

    localparam int FLAG_W        = 14;
    localparam int NUM_FLAGS_DEF = 16;
    localparam int MAX_FLAG_DEF  = 9999;

    localparam logic ACT_FORMULA = 1'b0;
    localparam logic ACT_TEST    = 1'b1;

    typedef enum logic [2:0] {
        OP_SET = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_INC = 3'd3,
        OP_DEC = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        CMP_ALWAYS = 3'd0,
        CMP_EQ     = 3'd1,
        CMP_NE     = 3'd2,
        CMP_GT     = 3'd3,
        CMP_GE     = 3'd4,
        CMP_LT     = 3'd5,
        CMP_LE     = 3'd6
    } cmp_t;

    typedef struct packed {
        logic              action;
        logic [3:0]        flag_index;
        logic [2:0]        operation;
        logic              indirect;
        logic [FLAG_W-1:0] operand;
        logic [2:0]        comparator;
        logic [FLAG_W-1:0] ref_value;
    } item_t;

    typedef struct packed {
        logic              link_taken;
        logic [FLAG_W-1:0] flag_value;
    } result_t;

endpackage

`default_nettype wire

// ===== design/lfce_flag_file.sv =====
// ----------------------------------------------------------------------------
// Loop flag file
// Flag memory with one write port and two registered read ports. Per-entry
// valid bits make never-written flags read as zero; a read that hits the
// write of the same cycle returns the new value.
// ----------------------------------------------------------------------------
`default_nettype none

module lfce_flag_file
    import lfce_pkg::*;
#(
    parameter  int NUM_FLAGS = NUM_FLAGS_DEF,
    localparam int IDX_W     = $clog2(NUM_FLAGS)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr_a,
    input  wire logic [IDX_W-1:0]  rd_addr_b,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire logic [FLAG_W-1:0] wr_data,
    output logic      [FLAG_W-1:0] rd_data_a,
    output logic      [FLAG_W-1:0] rd_data_b
);

    logic [FLAG_W-1:0]    flag_mem [NUM_FLAGS];
    logic [NUM_FLAGS-1:0] vld_reg;
    logic [FLAG_W-1:0]    rd_a_reg;
    logic [FLAG_W-1:0]    rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            flag_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // write-first: bypass the same-cycle update
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr_a))
                rd_a_reg <= wr_data;
            else if (vld_reg[rd_addr_a])
                rd_a_reg <= flag_mem[rd_addr_a];
            else
                rd_a_reg <= '0;

            if (wr_en && (wr_addr == rd_addr_b))
                rd_b_reg <= wr_data;
            else if (vld_reg[rd_addr_b])
                rd_b_reg <= flag_mem[rd_addr_b];
            else
                rd_b_reg <= '0;
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

// ===== design/loop_flag_condition_engine_core.sv =====
// ----------------------------------------------------------------------------
// Loop flag condition engine
// Applies label formulas to a file of loop flags and tests link conditions
// against them, one result per item.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake                   | payload
//   ---------+-----+-----------------------------+----------------
//   item     | in  | item_valid / item_ready     | item_t
//   result   | out | result_valid / result_ready | result_t
//
// One item per cycle sustained while results are taken. The flag reads
// register together with the item, and the update and compare then load the
// result register once the result register is free or being taken.
// Reset clears all flags to zero at once through per-flag valid bits.
// A stalled result holds the compute stage; item_ready drops only while both
// the compute stage and the result register are full.
// ----------------------------------------------------------------------------
`default_nettype none

module loop_flag_condition_engine_core
    import lfce_pkg::*;
#(
    parameter int NUM_FLAGS = NUM_FLAGS_DEF,
    parameter int MAX_FLAG  = MAX_FLAG_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    localparam int                IDX_W = $clog2(NUM_FLAGS);
    localparam logic [FLAG_W-1:0] MAX_V = FLAG_W'(MAX_FLAG);

    function automatic logic [IDX_W-1:0] clip_index(input logic [FLAG_W-1:0] v);
        if (32'(v) > 32'(NUM_FLAGS - 1))
            return IDX_W'(NUM_FLAGS - 1);
        else
            return IDX_W'(v);
    endfunction

    function automatic logic [FLAG_W-1:0] clip_value(input logic [FLAG_W-1:0] v);
        if (32'(v) > 32'(MAX_FLAG))
            return MAX_V;
        else
            return v;
    endfunction

    logic              s1_valid_reg;
    logic              s1_valid_next;
    item_t             s1_item_reg;
    logic              result_valid_reg;
    logic              result_valid_next;
    result_t           result_reg;
    result_t           result_next;

    logic              item_xfer;
    logic              s1_adv;
    logic [FLAG_W-1:0] cur;
    logic [FLAG_W-1:0] ind;
    logic [FLAG_W-1:0] arg;
    logic [FLAG_W-1:0] refv;
    logic [FLAG_W:0]   sum;
    logic [FLAG_W-1:0] new_val;
    logic              known;
    logic              taken;
    logic              is_formula;
    logic              wr_en;

    assign item_xfer  = item_valid && item_ready;
    assign s1_adv     = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || s1_adv;

    lfce_flag_file #(
        .NUM_FLAGS (NUM_FLAGS)
    ) u_flags (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (item_xfer),
        .rd_addr_a (clip_index(FLAG_W'(item.flag_index))),
        .rd_addr_b (clip_index(item.operand)),
        .wr_en     (wr_en),
        .wr_addr   (clip_index(FLAG_W'(s1_item_reg.flag_index))),
        .wr_data   (new_val),
        .rd_data_a (cur),
        .rd_data_b (ind)
    );

    always_comb
    begin
        arg        = s1_item_reg.indirect ? ind : clip_value(s1_item_reg.operand);
        refv       = clip_value(s1_item_reg.ref_value);
        sum        = {1'b0, cur} + {1'b0, arg};
        new_val    = cur;
        known      = 1'b1;
        taken      = 1'b0;
        is_formula = (s1_item_reg.action == ACT_FORMULA);

        case (s1_item_reg.operation)
            OP_SET: new_val = arg;
            OP_ADD: new_val = (32'(sum) > 32'(MAX_FLAG)) ? MAX_V : sum[FLAG_W-1:0];
            OP_SUB: new_val = (cur >= arg) ? cur - arg : '0;
            OP_INC: new_val = (32'(cur) >= 32'(MAX_FLAG)) ? MAX_V : cur + FLAG_W'(1);
            OP_DEC: new_val = (cur != '0) ? cur - FLAG_W'(1) : '0;
            default: known = 1'b0;
        endcase

        case (s1_item_reg.comparator)
            CMP_ALWAYS: taken = 1'b1;
            CMP_EQ:     taken = (cur == refv);
            CMP_NE:     taken = (cur != refv);
            CMP_GT:     taken = (cur >  refv);
            CMP_GE:     taken = (cur >= refv);
            CMP_LT:     taken = (cur <  refv);
            CMP_LE:     taken = (cur <= refv);
            default:    taken = 1'b0;
        endcase

        wr_en = s1_adv && is_formula && known;

        result_next.link_taken = is_formula ? 1'b0 : taken;
        result_next.flag_value = is_formula ? new_val : cur;

        s1_valid_next = item_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        result_valid_next = s1_adv ? 1'b1 : (result_ready ? 1'b0 : result_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            s1_item_reg <= item;
        end
        if (s1_adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== design/lfce_checker.sv =====
// ----------------------------------------------------------------------------
// Loop flag condition engine checker
// Port-level assertions on result holding, flag range and backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module lfce_checker
    import lfce_pkg::*;
#(
    parameter int MAX_FLAG = MAX_FLAG_DEF
)
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_ready,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire result_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before transfer");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("stalled result changed");

    // flags never leave the saturation range
    a_flag_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (32'(result.flag_value) <= 32'(MAX_FLAG)))
        else $error("flag value above maximum");

    // input only backs up behind a stalled result
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("item_ready low without output stall");

endmodule

bind loop_flag_condition_engine_core lfce_checker #(
    .MAX_FLAG (MAX_FLAG)
) u_lfce_checker (.*);

`default_nettype wire
